// ----- src/assert_macros.svh -----
// Assertion macros shared by the vector angle unit RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/vau_pkg.sv -----
// Shared constants and the arctangent table for the vector angle unit.
// No dependencies; imported by every module of the block except vau_out_buf.
`default_nettype none

package vau_pkg;

  localparam int COMP_W      = 16;
  localparam int CORDIC_ITER = 16;
  localparam int ATAN_LEN    = 24;
  localparam int ANG_W       = 32;
  localparam int OUT_W       = 15;

  localparam logic [25:0]      GAIN_SQ_Q24 = 26'd45496779;
  localparam logic [ANG_W-1:0] PI_Q30      = 32'd3373259426;
  localparam logic [21:0]      RAD2DEG_Q16 = 22'd3754936;
  localparam logic [OUT_W-1:0] MAX_RAD_Q13 = 15'd25736;
  localparam logic [OUT_W-1:0] MAX_DEG_Q7  = 15'd23040;

  // atan(2^-i) in Q2.30 radians.
  function automatic logic [ANG_W-1:0] atan_q30(input int i);
    logic [ANG_W-1:0] v;
    case (i)
      0:       v = 32'd843314857;
      1:       v = 32'd497837829;
      2:       v = 32'd263043837;
      3:       v = 32'd133525159;
      4:       v = 32'd67021687;
      5:       v = 32'd33543516;
      6:       v = 32'd16775851;
      7:       v = 32'd8388437;
      8:       v = 32'd4194283;
      9:       v = 32'd2097149;
      10:      v = 32'd1048576;
      11:      v = 32'd524288;
      12:      v = 32'd262144;
      13:      v = 32'd131072;
      14:      v = 32'd65536;
      15:      v = 32'd32768;
      16:      v = 32'd16384;
      17:      v = 32'd8192;
      18:      v = 32'd4096;
      19:      v = 32'd2048;
      20:      v = 32'd1024;
      21:      v = 32'd512;
      22:      v = 32'd256;
      23:      v = 32'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- src/vector_angle_unit.sv -----
// Top level of the vector angle unit: front end, three CORDIC passes, back end.
// Depends on vau_pkg, vau_front, vau_cordic, vau_back, vau_out_buf and assert_macros.svh.
//
// Returns the unsigned angle between two signed 3D vectors as atan2(|a x b|, a.b),
// in Q2.13 radians or, with unit_degrees set, Q8.7 degrees. The block is fully
// pipelined and takes one vector pair per clock cycle while not stalled; each result passes
// through the five front-end stages, one stage per iteration in each of the three
// CORDIC passes, three back-end stages and the output register. A two-entry output
// buffer keeps in_tready registered; when the consumer stalls the whole pipeline
// holds. Write unit_degrees only while no item is in flight.
`default_nettype none

`include "assert_macros.svh"

module vector_angle_unit
  import vau_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER,
  parameter int COMPONENT_WIDTH   = COMP_W
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata, from bit 0 up: a_x, a_y, a_z, b_x, b_y, b_z, zero fill to bytes.
  input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // out_tdata, from bit 0 up: angle, one zero bit.
  output logic [15:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  localparam int W      = COMPONENT_WIDTH;
  localparam int XW     = 2*W+5;
  localparam int DSW    = 2*W+2;
  localparam int NSTG   = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
  localparam int S1W    = 2*W + DSW + 1;
  localparam int S2W    = DSW + 1;

  logic unit_degrees_r;
  logic en;

  logic                 f_vld, f_dneg;
  logic [2*W-1:0]       f_cx, f_cy, f_cz;
  logic [DSW-1:0]       f_dsc;

  logic                 p1_vld;
  logic signed [XW-1:0] p1_x;
  logic [S1W-1:0]       p1_side;
  logic [2*W-1:0]       p1_cz;
  logic [DSW-1:0]       p1_dsc;
  logic                 p1_dneg;

  logic                 p2_vld;
  logic signed [XW-1:0] p2_x;
  logic [S2W-1:0]       p2_side;
  logic [DSW-1:0]       p2_dsc;
  logic                 p2_dneg;
  logic                 p2_zero;

  logic                    p3_vld;
  logic signed [ANG_W-1:0] p3_z;
  logic [1:0]              p3_side;

  logic             b_vld;
  logic [OUT_W-1:0] b_angle, o_angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_degrees_r <= 1'b0;
    end else if (cfg_valid) begin
      unit_degrees_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_tready = en;

  vau_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (in_tvalid),
    .ax_i     (in_tdata[W-1:0]),
    .ay_i     (in_tdata[2*W-1:W]),
    .az_i     (in_tdata[3*W-1:2*W]),
    .bx_i     (in_tdata[4*W-1:3*W]),
    .by_i     (in_tdata[5*W-1:4*W]),
    .bz_i     (in_tdata[6*W-1:5*W]),
    .vld_o    (f_vld),
    .cx_mag_o (f_cx),
    .cy_mag_o (f_cy),
    .cz_mag_o (f_cz),
    .dsc_o    (f_dsc),
    .dneg_o   (f_dneg)
  );

  // First pass: length of (cx, cy).
  vau_cordic #(.XW(XW), .SW(S1W), .STAGES(NSTG)) u_pass_xy (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (f_vld),
    .x_i    (XW'(f_cx)),
    .y_i    (XW'(f_cy)),
    .side_i ({f_cz, f_dsc, f_dneg}),
    .vld_o  (p1_vld),
    .x_o    (p1_x),
    .z_o    (),
    .side_o (p1_side)
  );

  assign {p1_cz, p1_dsc, p1_dneg} = p1_side;

  // Second pass: folds in cz to give the scaled cross-product length.
  vau_cordic #(.XW(XW), .SW(S2W), .STAGES(NSTG)) u_pass_len (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (p1_vld),
    .x_i    (p1_x),
    .y_i    (XW'(p1_cz)),
    .side_i ({p1_dsc, p1_dneg}),
    .vld_o  (p2_vld),
    .x_o    (p2_x),
    .z_o    (),
    .side_o (p2_side)
  );

  assign {p2_dsc, p2_dneg} = p2_side;
  assign p2_zero = (p2_x == '0) && (p2_dsc == '0);

  // Third pass: atan2(length, |dot|).
  vau_cordic #(.XW(XW), .SW(2), .STAGES(NSTG)) u_pass_ang (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (p2_vld),
    .x_i    (XW'(p2_dsc)),
    .y_i    (p2_x),
    .side_i ({p2_zero, p2_dneg}),
    .vld_o  (p3_vld),
    .x_o    (),
    .z_o    (p3_z),
    .side_o (p3_side)
  );

  vau_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (p3_vld),
    .zero_i  (p3_side[1]),
    .dneg_i  (p3_side[0]),
    .z_i     (p3_z),
    .unit_i  (unit_degrees_r),
    .vld_o   (b_vld),
    .angle_o (b_angle)
  );

  vau_out_buf #(.DW(OUT_W)) u_out_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_vld_i  (b_vld & en),
    .push_data_i (b_angle),
    .ready_o     (en),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (o_angle)
  );

  assign out_tdata = {1'b0, o_angle};

  `ASSERT_CLK(a_rad_range, (out_tvalid && !unit_degrees_r) |-> (o_angle <= MAX_RAD_Q13), "radian result above pi")
  `ASSERT_CLK(a_deg_range, (out_tvalid && unit_degrees_r) |-> (o_angle <= MAX_DEG_Q7), "degree result above 180")

endmodule

`default_nettype wire

// ----- src/vau_front.sv -----
// Front end: cross and dot products, magnitudes, and the gain scaling of |dot|.
// Five register stages; depends on vau_pkg.
`default_nettype none

module vau_front
  import vau_pkg::*;
#(
  parameter int W = COMP_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic signed [W-1:0]   ax_i,
  input  logic signed [W-1:0]   ay_i,
  input  logic signed [W-1:0]   az_i,
  input  logic signed [W-1:0]   bx_i,
  input  logic signed [W-1:0]   by_i,
  input  logic signed [W-1:0]   bz_i,
  output logic                  vld_o,
  output logic [2*W-1:0]        cx_mag_o,
  output logic [2*W-1:0]        cy_mag_o,
  output logic [2*W-1:0]        cz_mag_o,
  output logic [2*W+1:0]        dsc_o,
  output logic                  dneg_o
);

  localparam int PW = 2*W;
  localparam int SW = 2*W+2;

  logic [4:0] vld_r;

  logic signed [PW-1:0] m_nxt [0:8];
  logic signed [PW-1:0] m_r   [0:8];

  logic signed [SW-1:0] cx_r, cy_r, cz_r, dot_r;

  logic [PW-1:0] cxm3_r, cym3_r, czm3_r, dm3_r;
  logic          dneg3_r;

  logic [63:0]   dm64;
  logic [57:0]   plo_r, phi_r;
  logic [PW-1:0] cxm4_r, cym4_r, czm4_r;
  logic          dneg4_r;

  logic [PW-1:0] cxm5_r, cym5_r, czm5_r;
  logic [SW-1:0] dsc5_r;
  logic          dneg5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_comb begin
    m_nxt[0] = ay_i * bz_i;
    m_nxt[1] = az_i * by_i;
    m_nxt[2] = az_i * bx_i;
    m_nxt[3] = ax_i * bz_i;
    m_nxt[4] = ax_i * by_i;
    m_nxt[5] = ay_i * bx_i;
    m_nxt[6] = ax_i * bx_i;
    m_nxt[7] = ay_i * by_i;
    m_nxt[8] = az_i * bz_i;
  end

  assign dm64 = 64'(dm3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;

      cx_r  <= SW'(m_r[0]) - SW'(m_r[1]);
      cy_r  <= SW'(m_r[2]) - SW'(m_r[3]);
      cz_r  <= SW'(m_r[4]) - SW'(m_r[5]);
      dot_r <= SW'(m_r[6]) + SW'(m_r[7]) + SW'(m_r[8]);

      cxm3_r  <= cx_r[SW-1]  ? PW'(-cx_r)  : PW'(cx_r);
      cym3_r  <= cy_r[SW-1]  ? PW'(-cy_r)  : PW'(cy_r);
      czm3_r  <= cz_r[SW-1]  ? PW'(-cz_r)  : PW'(cz_r);
      dm3_r   <= dot_r[SW-1] ? PW'(-dot_r) : PW'(dot_r);
      dneg3_r <= dot_r[SW-1];

      // The gain product is split into two 32-bit partial products.
      plo_r   <= 58'(dm64[31:0]) * 58'(GAIN_SQ_Q24);
      phi_r   <= 58'(dm64[63:32]) * 58'(GAIN_SQ_Q24);
      cxm4_r  <= cxm3_r;
      cym4_r  <= cym3_r;
      czm4_r  <= czm3_r;
      dneg4_r <= dneg3_r;

      dsc5_r  <= SW'((64'(phi_r) << 8) + 64'(plo_r >> 24));
      cxm5_r  <= cxm4_r;
      cym5_r  <= cym4_r;
      czm5_r  <= czm4_r;
      dneg5_r <= dneg4_r;
    end
  end

  assign vld_o    = vld_r[4];
  assign cx_mag_o = cxm5_r;
  assign cy_mag_o = cym5_r;
  assign cz_mag_o = czm5_r;
  assign dsc_o    = dsc5_r;
  assign dneg_o   = dneg5_r;

endmodule

`default_nettype wire

// ----- src/vau_cordic.sv -----
// One CORDIC vectoring pass, one register stage per iteration.
// Carries a side payload alongside; depends on vau_pkg for the arctangent table.
`default_nettype none

module vau_cordic
  import vau_pkg::*;
#(
  parameter int XW     = 2*COMP_W+5,
  parameter int SW     = 1,
  parameter int STAGES = CORDIC_ITER
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic signed [XW-1:0]    x_i,
  input  logic signed [XW-1:0]    y_i,
  input  logic [SW-1:0]           side_i,
  output logic                    vld_o,
  output logic signed [XW-1:0]    x_o,
  output logic signed [ANG_W-1:0] z_o,
  output logic [SW-1:0]           side_o
);

  logic                    vld_r  [1:STAGES];
  logic signed [XW-1:0]    x_r    [1:STAGES];
  logic signed [XW-1:0]    y_r    [1:STAGES];
  logic signed [ANG_W-1:0] z_r    [1:STAGES];
  logic [SW-1:0]           side_r [1:STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_q30(i);

    logic                    vc;
    logic signed [XW-1:0]    xc, yc;
    logic signed [ANG_W-1:0] zc;
    logic [SW-1:0]           sc;

    if (i == 0) begin : g_first
      assign vc = vld_i;
      assign xc = x_i;
      assign yc = y_i;
      assign zc = '0;
      assign sc = side_i;
    end else begin : g_next
      assign vc = vld_r[i];
      assign xc = x_r[i];
      assign yc = y_r[i];
      assign zc = z_r[i];
      assign sc = side_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vc;
      end
    end

    // Rotate toward the x axis; the sign of y picks the direction.
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= sc;
        if (!yc[XW-1]) begin
          x_r[i+1] <= xc + (yc >>> i);
          y_r[i+1] <= yc - (xc >>> i);
          z_r[i+1] <= zc + ATAN_I;
        end else begin
          x_r[i+1] <= xc - (yc >>> i);
          y_r[i+1] <= yc + (xc >>> i);
          z_r[i+1] <= zc - ATAN_I;
        end
      end
    end
  end

  assign vld_o  = vld_r[STAGES];
  assign x_o    = x_r[STAGES];
  assign z_o    = z_r[STAGES];
  assign side_o = side_r[STAGES];

endmodule

`default_nettype wire

// ----- src/vau_back.sv -----
// Back end: obtuse-angle fold, clamp to 0..pi and conversion to the output unit.
// Three register stages; depends on vau_pkg.
`default_nettype none

module vau_back
  import vau_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic                    zero_i,
  input  logic                    dneg_i,
  input  logic signed [ANG_W-1:0] z_i,
  input  logic                    unit_i,
  output logic                    vld_o,
  output logic [OUT_W-1:0]        angle_o
);

  localparam int TW = ANG_W+2;
  localparam logic signed [TW-1:0] PI_T = {2'b00, PI_Q30};

  logic [2:0]         vld_r;
  logic signed [TW-1:0] t;
  logic [ANG_W-1:0]   ang_nxt, ang_r;
  logic [53:0]        deg_r;
  logic [15:0]        rad_r;
  logic [15:0]        degv, radv;
  logic [OUT_W-1:0]   angle_nxt, angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_comb begin
    if (zero_i) begin
      t = '0;
    end else if (dneg_i) begin
      t = PI_T - TW'(z_i);
    end else begin
      t = TW'(z_i);
    end
    if (t[TW-1]) begin
      ang_nxt = '0;
    end else if (t > PI_T) begin
      ang_nxt = PI_Q30;
    end else begin
      ang_nxt = t[ANG_W-1:0];
    end
  end

  always_comb begin
    degv = 16'((55'(deg_r) + (55'd1 << 38)) >> 39);
    radv = rad_r;
    if (unit_i) begin
      angle_nxt = (degv > 16'(MAX_DEG_Q7)) ? MAX_DEG_Q7 : degv[OUT_W-1:0];
    end else begin
      angle_nxt = (radv > 16'(MAX_RAD_Q13)) ? MAX_RAD_Q13 : radv[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r   <= ang_nxt;
      deg_r   <= 54'(ang_r) * 54'(RAD2DEG_Q16);
      rad_r   <= 16'((33'(ang_r) + 33'd65536) >> 17);
      angle_r <= angle_nxt;
    end
  end

  assign vld_o   = vld_r[2];
  assign angle_o = angle_r;

endmodule

`default_nettype wire

// ----- src/vau_out_buf.sv -----
// Output register with a skid stage, so the pipeline enable comes from a flop.
// Depends on assert_macros.svh for its checks.
`default_nettype none

`include "assert_macros.svh"

module vau_out_buf #(
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_vld_i,
  input  logic [DW-1:0] push_data_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [DW-1:0] out_data_o
);

  logic          out_valid_r, skid_valid_r;
  logic [DW-1:0] out_data_r, skid_data_r;
  logic          pop;

  assign pop = out_valid_r & out_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push_vld_i;
    end else if (push_vld_i) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || pop) begin
      out_data_r <= push_data_i;
    end else begin
      skid_data_r <= push_data_i;
    end
  end

  assign ready_o     = !skid_valid_r;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

  `ASSERT_CLK(a_skid_behind_head, skid_valid_r |-> out_valid_r, "skid full with empty head")
  `ASSERT_CLK(a_stall_fills_skid, (out_valid_r && !out_ready_i && push_vld_i) |=> skid_valid_r, "stalled transfer not caught by skid")
  `ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !skid_valid_r, "buffer not empty after reset")

endmodule

`default_nettype wire
